### design/bcd_rtc_calendar_registers_unit_assert.svh
// assertion macros for the bcd real-time clock register unit
`ifndef BCD_RTC_CALENDAR_REGISTERS_UNIT_ASSERT_SVH
`define BCD_RTC_CALENDAR_REGISTERS_UNIT_ASSERT_SVH

// checked only while out of reset
`define BCDRTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define BCDRTC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/bcdrtc_pkg.sv
// shared types, register codes and lookup functions for the bcd real-time clock
package bcdrtc_pkg;

  // request kinds
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // register addresses
  localparam logic [3:0] ADDR_STATUS     = 4'd0;
  localparam logic [3:0] ADDR_TENTHS     = 4'd1;
  localparam logic [3:0] ADDR_LAST_DIGIT = 4'd13;
  localparam logic [3:0] ADDR_WEEKDAY    = 4'd14;

  // digit slots
  localparam int NUM_DIGITS = 13;
  localparam int D_TEN = 0;
  localparam int D_SU  = 1;
  localparam int D_ST  = 2;
  localparam int D_MU  = 3;
  localparam int D_MT  = 4;
  localparam int D_HU  = 5;
  localparam int D_HT  = 6;
  localparam int D_DU  = 7;
  localparam int D_DT  = 8;
  localparam int D_MOU = 9;
  localparam int D_MOT = 10;
  localparam int D_YU  = 11;
  localparam int D_YT  = 12;

  // register bit positions
  localparam int ST_DCF   = 3;
  localparam int ST_IF    = 0;
  localparam int CT_STOP  = 2;
  localparam int CT_ISEL  = 1;
  localparam int CT_ISTOP = 0;
  localparam int CS_LEAP_HI = 3;
  localparam int CS_LEAP_LO = 2;
  localparam int CS_PM    = 1;
  localparam int CS_24    = 0;
  localparam int IS_RPT   = 3;

  localparam logic [3:0] CS_PM_MASK = 4'h2;

  typedef logic [3:0] nibble_t;
  typedef logic [9:0] count_t;

  typedef struct packed {
    logic [1:0] req_type;
    nibble_t    reg_addr;
    nibble_t    write_data;
  } item_t;

  typedef struct packed {
    nibble_t read_data;
    logic    irq_flag;
  } result_t;

  // two bcd digits as a binary value, up to 165
  function automatic logic [7:0] bcd_pair(input nibble_t tens, input nibble_t units);
    logic [7:0] t;
    t = {4'b0, tens};
    return (t << 3) + (t << 1) + {4'b0, units};
  endfunction

  // interrupt delay in ticks
  function automatic count_t delay_ticks(input logic [2:0] sel);
    count_t d;
    unique case (sel)
      3'd0: d = 10'd0;
      3'd1: d = 10'd1;
      3'd2: d = 10'd5;
      3'd3: d = 10'd10;
      3'd4: d = 10'd50;
      3'd5: d = 10'd100;
      3'd6: d = 10'd300;
      default: d = 10'd600;
    endcase
    return d;
  endfunction

  // days in a month, non-leap february; anything else counts as 31
  function automatic logic [5:0] month_days(input logic [7:0] m);
    logic [5:0] n;
    unique case (m)
      8'd2: n = 6'd28;
      8'd4, 8'd6, 8'd9, 8'd11: n = 6'd30;
      default: n = 6'd31;
    endcase
    return n;
  endfunction

endpackage

### design/bcd_rtc_calendar_registers_unit.sv
// bcd real-time clock and calendar register unit, top level
//
// Each input transfer is a register read, a register write or a tenth-second
// tick, and each one yields exactly one result transfer carrying the read
// nibble (zero for anything but a read) and the interrupt flag as it stands
// after the request. One request is taken per cycle while the output is not
// stalled. A request waits in the input register until the result register
// can take it, is executed in a single pass through the register file and
// carry logic, and lands in the result register, from which it is presented
// until transferred. While a result waits, the input register still takes one
// more request; after that the input stalls until the result is transferred.
module bcd_rtc_calendar_registers_unit import bcdrtc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [3:0] reg_addr, [7:4] write_data
  input  logic [1:0] in_tuser,   // [1:0] req_type
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [3:0] read_data, [4] irq_flag, [7:5] zero
);

  item_t   in_item;
  item_t   hold_item;
  logic    hold_valid;
  logic    hold_take;
  result_t step_result;
  result_t out_result;

  assign in_item.req_type   = in_tuser;
  assign in_item.reg_addr   = in_tdata[3:0];
  assign in_item.write_data = in_tdata[7:4];

  bcdrtc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .hold_take  (hold_take)
  );

  bcdrtc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (hold_take),
    .item    (hold_item),
    .result  (step_result)
  );

  bcdrtc_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_valid  (hold_valid),
    .load_take   (hold_take),
    .load_result (step_result),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_result  (out_result)
  );

  assign out_tdata = {3'b000, out_result.irq_flag, out_result.read_data};

endmodule

### design/bcdrtc_in_reg.sv
// input holding register for incoming request transfers
module bcdrtc_in_reg import bcdrtc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  hold_valid,
  output item_t hold_item,
  input  logic  hold_take
);

  logic  vld_r;
  item_t item_r;

  assign in_ready   = !vld_r || hold_take;
  assign hold_valid = vld_r;
  assign hold_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

### design/bcdrtc_core.sv
// register file, time and calendar counters and interrupt timer
module bcdrtc_core import bcdrtc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  output result_t result
);

  nibble_t ctl_r, ctl_nxt;
  nibble_t sts_r, sts_nxt;
  nibble_t cs_r,  cs_nxt;
  nibble_t is_r,  is_nxt;
  nibble_t wd_r,  wd_nxt;
  nibble_t dig_r   [NUM_DIGITS];
  nibble_t dig_nxt [NUM_DIGITS];
  count_t  cnt_r, cnt_nxt;
  logic    arm_r, arm_nxt;

  nibble_t    rd;
  count_t     dly_cur;
  count_t     dly_wr;
  count_t     cnt_dec;
  logic       roll;
  logic       day_roll;
  logic       h24;
  logic [7:0] hour_pair;
  logic [7:0] mon_pair;
  logic [7:0] day_pair;
  logic [5:0] mon_len;

  assign dly_cur = delay_ticks(is_r[2:0]);
  assign dly_wr  = delay_ticks(item.write_data[2:0]);
  assign h24     = cs_r[CS_24];

  always_comb begin
    ctl_nxt   = ctl_r;
    sts_nxt   = sts_r;
    cs_nxt    = cs_r;
    is_nxt    = is_r;
    wd_nxt    = wd_r;
    dig_nxt   = dig_r;
    cnt_nxt   = cnt_r;
    arm_nxt   = arm_r;
    rd        = 4'd0;
    cnt_dec   = cnt_r;
    roll      = 1'b0;
    day_roll  = 1'b0;
    hour_pair = 8'd0;
    mon_pair  = 8'd0;
    day_pair  = 8'd0;
    mon_len   = 6'd31;

    unique case (item.req_type)
      REQ_READ: begin
        priority if (item.reg_addr == ADDR_STATUS) begin
          rd      = sts_r;
          sts_nxt = 4'd0;
        end else if (item.reg_addr <= ADDR_LAST_DIGIT) begin
          rd = dig_r[item.reg_addr - 4'd1];
        end else if (item.reg_addr == ADDR_WEEKDAY) begin
          rd = wd_r;
        end else if (ctl_r[CT_ISEL]) begin
          rd = is_r;
        end else if (cs_r[CS_24]) begin
          rd = cs_r & ~CS_PM_MASK;
        end else begin
          rd = cs_r;
        end
      end

      REQ_WRITE: begin
        priority if (item.reg_addr == ADDR_STATUS) begin
          if (!ctl_r[CT_ISTOP] && item.write_data[CT_ISTOP]) begin
            arm_nxt = 1'b0;
          end else if (ctl_r[CT_ISTOP] && !item.write_data[CT_ISTOP]) begin
            cnt_nxt = dly_cur;
            arm_nxt = (dly_cur != 10'd0);
          end
          if (item.write_data[CT_STOP]) begin
            dig_nxt[D_TEN] = 4'd0;
          end
          ctl_nxt = item.write_data;
        end else if (item.reg_addr == ADDR_TENTHS) begin
          // tenths are read-only
          rd = 4'd0;
        end else if (item.reg_addr <= ADDR_LAST_DIGIT) begin
          dig_nxt[item.reg_addr - 4'd1] = item.write_data;
        end else if (item.reg_addr == ADDR_WEEKDAY) begin
          wd_nxt = item.write_data;
        end else if (ctl_r[CT_ISEL]) begin
          is_nxt = item.write_data;
          if (!ctl_r[CT_ISTOP]) begin
            cnt_nxt = dly_wr;
            arm_nxt = (dly_wr != 10'd0);
          end
        end else begin
          cs_nxt = item.write_data;
        end
      end

      REQ_TICK: begin
        if (!ctl_r[CT_STOP]) begin
          sts_nxt[ST_DCF] = 1'b1;
          // time of day carry chain
          dig_nxt[D_TEN] = dig_r[D_TEN] + 4'd1;
          roll = (dig_nxt[D_TEN] == 4'd10);
          if (roll) begin
            dig_nxt[D_TEN] = 4'd0;
            dig_nxt[D_SU]  = dig_r[D_SU] + 4'd1;
            roll = (dig_nxt[D_SU] == 4'd10);
          end
          if (roll) begin
            dig_nxt[D_SU] = 4'd0;
            dig_nxt[D_ST] = dig_r[D_ST] + 4'd1;
            roll = (dig_nxt[D_ST] == 4'd6);
          end
          if (roll) begin
            dig_nxt[D_ST] = 4'd0;
            dig_nxt[D_MU] = dig_r[D_MU] + 4'd1;
            roll = (dig_nxt[D_MU] == 4'd10);
          end
          if (roll) begin
            dig_nxt[D_MU] = 4'd0;
            dig_nxt[D_MT] = dig_r[D_MT] + 4'd1;
            roll = (dig_nxt[D_MT] == 4'd6);
          end
          if (roll) begin
            // hours
            dig_nxt[D_MT] = 4'd0;
            dig_nxt[D_HU] = dig_r[D_HU] + 4'd1;
            if (dig_nxt[D_HU] == 4'd10) begin
              dig_nxt[D_HU] = 4'd0;
              dig_nxt[D_HT] = dig_r[D_HT] + 4'd1;
            end
            hour_pair = bcd_pair(dig_nxt[D_HT], dig_nxt[D_HU]);
            if (!h24 && hour_pair == 8'd12) begin
              cs_nxt[CS_PM] = ~cs_r[CS_PM];
            end
            if (!h24 && hour_pair == 8'd13) begin
              dig_nxt[D_HT] = 4'd0;
              dig_nxt[D_HU] = 4'd1;
            end
            if (h24 && hour_pair == 8'd24) begin
              dig_nxt[D_HT] = 4'd0;
              dig_nxt[D_HU] = 4'd0;
            end
            hour_pair = bcd_pair(dig_nxt[D_HT], dig_nxt[D_HU]);
            day_roll  = h24 ? (hour_pair == 8'd0)
                            : (hour_pair == 8'd12 && !cs_nxt[CS_PM]);
          end
          if (day_roll) begin
            // calendar
            dig_nxt[D_DU] = dig_r[D_DU] + 4'd1;
            if (dig_nxt[D_DU] == 4'd10) begin
              dig_nxt[D_DU] = 4'd0;
              dig_nxt[D_DT] = dig_r[D_DT] + 4'd1;
            end
            wd_nxt = wd_r + 4'd1;
            if (wd_nxt == 4'd8) begin
              wd_nxt = 4'd1;
            end
            mon_pair = bcd_pair(dig_r[D_MOT], dig_r[D_MOU]);
            if (mon_pair >= 8'd1 && mon_pair <= 8'd12) begin
              if (mon_pair == 8'd2 && cs_r[CS_LEAP_HI:CS_LEAP_LO] == 2'd0) begin
                mon_len = 6'd29;
              end else begin
                mon_len = month_days(mon_pair);
              end
            end
            day_pair = bcd_pair(dig_nxt[D_DT], dig_nxt[D_DU]);
            if (day_pair == {2'b0, mon_len} + 8'd1) begin
              dig_nxt[D_DT]  = 4'd0;
              dig_nxt[D_DU]  = 4'd1;
              dig_nxt[D_MOU] = dig_r[D_MOU] + 4'd1;
              if (dig_nxt[D_MOU] == 4'd10) begin
                dig_nxt[D_MOU] = 4'd0;
                dig_nxt[D_MOT] = dig_r[D_MOT] + 4'd1;
              end
              mon_pair = bcd_pair(dig_nxt[D_MOT], dig_nxt[D_MOU]);
              if (mon_pair == 8'd13) begin
                dig_nxt[D_MOT] = 4'd0;
                dig_nxt[D_MOU] = 4'd1;
                cs_nxt[CS_LEAP_HI:CS_LEAP_LO] = cs_r[CS_LEAP_HI:CS_LEAP_LO] + 2'd1;
                dig_nxt[D_YU] = dig_r[D_YU] + 4'd1;
                if (dig_nxt[D_YU] == 4'd10) begin
                  dig_nxt[D_YU] = 4'd0;
                  dig_nxt[D_YT] = dig_r[D_YT] + 4'd1;
                  if (dig_nxt[D_YT] == 4'd10) begin
                    dig_nxt[D_YT] = 4'd0;
                  end
                end
              end
            end
          end
        end
        // interrupt timer runs even while the clock is stopped
        if (arm_r) begin
          cnt_dec = (cnt_r != 10'd0) ? (cnt_r - 10'd1) : cnt_r;
          cnt_nxt = cnt_dec;
          if (cnt_dec == 10'd0) begin
            sts_nxt[ST_IF] = 1'b1;
            if (is_r[IS_RPT]) begin
              cnt_nxt = dly_cur;
              arm_nxt = (dly_cur != 10'd0);
            end else begin
              arm_nxt = 1'b0;
            end
          end
        end
      end

      default: begin
        rd = 4'd0;
      end
    endcase
  end

  assign result.read_data = rd;
  assign result.irq_flag  = sts_nxt[ST_IF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= 4'd0;
      sts_r <= 4'd0;
      cs_r  <= 4'd0;
      is_r  <= 4'd0;
      wd_r  <= 4'd0;
      cnt_r <= 10'd0;
      arm_r <= 1'b0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        dig_r[i] <= 4'd0;
      end
    end else if (step_en) begin
      ctl_r <= ctl_nxt;
      sts_r <= sts_nxt;
      cs_r  <= cs_nxt;
      is_r  <= is_nxt;
      wd_r  <= wd_nxt;
      cnt_r <= cnt_nxt;
      arm_r <= arm_nxt;
      dig_r <= dig_nxt;
    end
  end

endmodule

### design/bcdrtc_out_reg.sv
// result register driving the outgoing stream
module bcdrtc_out_reg import bcdrtc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load_valid,
  output logic    load_take,
  input  result_t load_result,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    vld_r;
  result_t res_r;

  assign load_take  = load_valid && (!vld_r || out_ready);
  assign out_valid  = vld_r;
  assign out_result = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load_take) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_take) begin
      res_r <= load_result;
    end
  end

endmodule

### design/bcdrtc_checker.sv
// port-level checks for the bcd real-time clock register unit
`include "bcd_rtc_calendar_registers_unit_assert.svh"

module bcdrtc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  `BCDRTC_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid, "result valid right after reset")

  `BCDRTC_ASSERT(a_pad_zero, out_tvalid |-> (out_tdata[7:5] == 3'b000), "result padding not zero")

  `BCDRTC_ASSERT(a_no_needless_stall, (!out_tvalid || out_tready) |-> in_tready, "input stalled while output free")

  `BCDRTC_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)), "stalled result changed")

endmodule

bind bcd_rtc_calendar_registers_unit bcdrtc_checker u_bcdrtc_checker (.*);
